// File: design/ptt_pkg.sv
// ----------------------------------------------------------------------------
// Periodic timer table package
// Shared request, result and entry types and the command and status codes.
// ----------------------------------------------------------------------------
package ptt_pkg;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_DEL = 2'd1;
  localparam logic [1:0] CMD_CHK = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_DUP   = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;
  localparam logic [1:0] STAT_EMPTY = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] timer_key;
    logic [30:0] interval_ms;
    logic [15:0] repeat_count;
    logic [47:0] now_ms;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        fired;
    logic [15:0] fired_key;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] key;
    logic [30:0] interval;
    logic [15:0] remaining;
    logic [47:0] last_time;
  } entry_t;

  typedef struct packed {
    logic   shift;
    entry_t wb;
  } ring_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DUP,
    S_INS,
    S_DEL,
    S_CHK,
    S_FIN
  } ctl_state_t;

endpackage

// File: design/ptt_cell.sv
// ----------------------------------------------------------------------------
// Periodic timer table cell
// Holds one timer entry and loads its d input (neighbor or write-back) on shift.
// ----------------------------------------------------------------------------
module ptt_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            shift,
  input  ptt_pkg::entry_t d,
  output ptt_pkg::entry_t q
);

  logic            valid_r;
  ptt_pkg::entry_t data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift) begin
      valid_r <= d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      data_r <= d;
    end
  end

  always_comb begin
    q       = data_r;
    q.valid = valid_r;
  end

endmodule

// File: design/ptt_ctrl.sv
// ----------------------------------------------------------------------------
// Periodic timer table controller
// Sequences ring passes and processes the entry at the head of the ring.
// ----------------------------------------------------------------------------
module ptt_ctrl #(
  parameter int SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ptt_pkg::req_t      in_data,
  output logic               out_strobe,
  output ptt_pkg::rsp_t      out_data,
  input  ptt_pkg::entry_t    head,
  output ptt_pkg::ring_ctl_t ring
);

  localparam int CW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TW = $clog2(SLOTS + 1);

  ptt_pkg::ctl_state_t state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [TW-1:0]       total_r, total_nxt;
  ptt_pkg::req_t       req_r;
  logic                flag_r, flag_nxt;
  ptt_pkg::entry_t     carry_r, carry_nxt;
  logic                carry_pend_r, carry_pend_nxt;
  logic                pend_r, pend_nxt;
  logic [15:0]         pend_key_r, pend_key_nxt;
  logic                out_valid_r, out_valid_nxt;
  ptt_pkg::rsp_t       out_data_r, out_data_nxt;
  logic                cnt_end;
  logic                key_hit;
  logic [48:0]         due;
  logic                due_hit;
  logic                accept;

  assign busy       = (state_r != ptt_pkg::S_IDLE);
  assign accept     = start && !busy;
  assign out_strobe = out_valid_r;
  assign out_data   = out_data_r;
  assign cnt_end    = (cnt_r == CW'(SLOTS - 1));
  assign key_hit    = head.valid && (head.key == req_r.timer_key);
  assign due        = {1'b0, head.last_time} + 49'(head.interval);
  assign due_hit    = head.valid && (due <= {1'b0, req_r.now_ms});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ptt_pkg::S_IDLE;
      cnt_r        <= '0;
      total_r      <= '0;
      flag_r       <= 1'b0;
      carry_pend_r <= 1'b0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      total_r      <= total_nxt;
      flag_r       <= flag_nxt;
      carry_pend_r <= carry_pend_nxt;
      pend_r       <= pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_data;
    end
    carry_r    <= carry_nxt;
    pend_key_r <= pend_key_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    total_nxt      = total_r;
    flag_nxt       = flag_r;
    carry_nxt      = carry_r;
    carry_pend_nxt = carry_pend_r;
    pend_nxt       = pend_r;
    pend_key_nxt   = pend_key_r;
    out_valid_nxt  = 1'b0;
    out_data_nxt   = '0;
    ring.shift     = 1'b0;
    ring.wb        = head;

    case (state_r)
      ptt_pkg::S_IDLE: begin
        cnt_nxt  = '0;
        flag_nxt = 1'b0;
        pend_nxt = 1'b0;
        if (accept) begin
          case (in_data.command)
            ptt_pkg::CMD_ADD: begin
              state_nxt = ptt_pkg::S_DUP;
            end
            ptt_pkg::CMD_DEL: begin
              if (total_r == '0) begin
                out_valid_nxt       = 1'b1;
                out_data_nxt.status = ptt_pkg::STAT_EMPTY;
                out_data_nxt.last   = 1'b1;
              end else begin
                state_nxt = ptt_pkg::S_DEL;
              end
            end
            ptt_pkg::CMD_CHK: begin
              state_nxt = ptt_pkg::S_CHK;
            end
            default: begin
              out_valid_nxt       = 1'b1;
              out_data_nxt.status = ptt_pkg::STAT_OK;
              out_data_nxt.last   = 1'b1;
            end
          endcase
        end
      end

      ptt_pkg::S_DUP: begin
        ring.shift = 1'b1;
        cnt_nxt    = cnt_r + 1'b1;
        flag_nxt   = flag_r || key_hit;
        if (cnt_end) begin
          cnt_nxt = '0;
          if (flag_r || key_hit) begin
            out_valid_nxt       = 1'b1;
            out_data_nxt.status = ptt_pkg::STAT_DUP;
            out_data_nxt.last   = 1'b1;
            state_nxt           = ptt_pkg::S_IDLE;
          end else if (total_r == TW'(SLOTS)) begin
            out_valid_nxt       = 1'b1;
            out_data_nxt.status = ptt_pkg::STAT_FULL;
            out_data_nxt.last   = 1'b1;
            state_nxt           = ptt_pkg::S_IDLE;
          end else begin
            carry_nxt.valid     = 1'b1;
            carry_nxt.key       = req_r.timer_key;
            carry_nxt.interval  = req_r.interval_ms;
            carry_nxt.remaining = req_r.repeat_count;
            carry_nxt.last_time = req_r.now_ms;
            carry_pend_nxt      = 1'b1;
            state_nxt           = ptt_pkg::S_INS;
          end
        end
      end

      ptt_pkg::S_INS: begin
        ring.shift = 1'b1;
        cnt_nxt    = cnt_r + 1'b1;
        if (carry_pend_r) begin
          ring.wb = carry_r;
          if (head.valid) begin
            carry_nxt = head;
          end else begin
            carry_pend_nxt = 1'b0;
          end
        end
        if (cnt_end) begin
          cnt_nxt             = '0;
          total_nxt           = total_r + 1'b1;
          out_valid_nxt       = 1'b1;
          out_data_nxt.status = ptt_pkg::STAT_OK;
          out_data_nxt.last   = 1'b1;
          state_nxt           = ptt_pkg::S_IDLE;
        end
      end

      ptt_pkg::S_DEL: begin
        ring.shift = 1'b1;
        cnt_nxt    = cnt_r + 1'b1;
        if (!flag_r && key_hit) begin
          ring.wb.valid = 1'b0;
          flag_nxt      = 1'b1;
          total_nxt     = total_r - 1'b1;
        end
        if (cnt_end) begin
          cnt_nxt             = '0;
          out_valid_nxt       = 1'b1;
          out_data_nxt.status = ptt_pkg::STAT_OK;
          out_data_nxt.last   = 1'b1;
          state_nxt           = ptt_pkg::S_IDLE;
        end
      end

      ptt_pkg::S_CHK: begin
        ring.shift = 1'b1;
        cnt_nxt    = cnt_r + 1'b1;
        if (due_hit) begin
          ring.wb.last_time = due[47:0];
          if (head.remaining != '0) begin
            ring.wb.remaining = head.remaining - 1'b1;
            if (head.remaining == 16'd1) begin
              ring.wb.valid = 1'b0;
              total_nxt     = total_r - 1'b1;
            end
          end
          if (pend_r) begin
            out_valid_nxt          = 1'b1;
            out_data_nxt.status    = ptt_pkg::STAT_OK;
            out_data_nxt.fired     = 1'b1;
            out_data_nxt.fired_key = pend_key_r;
          end
          pend_nxt     = 1'b1;
          pend_key_nxt = head.key;
        end
        if (cnt_end) begin
          cnt_nxt   = '0;
          state_nxt = ptt_pkg::S_FIN;
        end
      end

      ptt_pkg::S_FIN: begin
        out_valid_nxt       = 1'b1;
        out_data_nxt.status = ptt_pkg::STAT_OK;
        out_data_nxt.last   = 1'b1;
        if (pend_r) begin
          out_data_nxt.fired     = 1'b1;
          out_data_nxt.fired_key = pend_key_r;
        end
        pend_nxt  = 1'b0;
        state_nxt = ptt_pkg::S_IDLE;
      end

      default: begin
        state_nxt = ptt_pkg::S_IDLE;
      end
    endcase
  end

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= TW'(SLOTS))
    else $error("timer count exceeds table size");

  a_insert_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ptt_pkg::S_INS && cnt_end) |=> !carry_pend_r)
    else $error("new timer was not placed during the insert pass");

  a_partial_in_check: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.last) |->
      (state_r == ptt_pkg::S_CHK || state_r == ptt_pkg::S_FIN))
    else $error("non-final result outside a check");

  a_fired_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.fired) |->
      (out_data_r.status == ptt_pkg::STAT_OK && $past(state_r) == ptt_pkg::S_CHK) ||
      (out_data_r.status == ptt_pkg::STAT_OK && $past(state_r) == ptt_pkg::S_FIN))
    else $error("firing reported outside a check");

  a_busy_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ptt_pkg::S_INS || state_r == ptt_pkg::S_DEL) |-> !out_valid_nxt || cnt_end)
    else $error("result issued in the middle of a pass");

endmodule

// File: design/periodic_timer_table.sv
// ----------------------------------------------------------------------------
// Periodic timer table
// An add is busy for a key scan pass over all SLOTS cells, plus an insert
// pass when it is taken; a delete for one pass, a check for one pass and the
// finish state; delete on an empty table and unused commands are never busy.
// The final result strobes in the cycle after the last busy cycle, and the next
// request can be taken in that cycle; fired results of a check come during the
// pass, one cycle each. Results cannot be stalled. Reset empties the table.
// ----------------------------------------------------------------------------
module periodic_timer_table #(
  parameter int SLOTS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  ptt_pkg::req_t in_data,
  output logic          out_strobe,
  output ptt_pkg::rsp_t out_data
);

  ptt_pkg::entry_t    chain [SLOTS];
  ptt_pkg::ring_ctl_t ring;

  ptt_ctrl #(
    .SLOTS(SLOTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data),
    .head      (chain[0]),
    .ring      (ring)
  );

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    if (i == SLOTS - 1) begin : g_tail
      ptt_cell u_cell (
        .clk  (clk),
        .rst_n(rst_n),
        .shift(ring.shift),
        .d    (ring.wb),
        .q    (chain[i])
      );
    end else begin : g_body
      ptt_cell u_cell (
        .clk  (clk),
        .rst_n(rst_n),
        .shift(ring.shift),
        .d    (chain[i+1]),
        .q    (chain[i])
      );
    end
  end

endmodule

// File: test/tb_periodic_timer_table.sv
// ----------------------------------------------------------------------------
// Periodic timer table testbench
// Drives add, delete and check requests in random bursts and gaps, keeps a
// shadow copy of the timer table to work out every expected result, and
// compares each strobed result field by field, in order, with those values.
// ----------------------------------------------------------------------------
module tb_periodic_timer_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 16;
  localparam logic [1:0] CMD_NOP = 2'd3;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  ptt_pkg::req_t in_data = '0;
  logic out_strobe;
  ptt_pkg::rsp_t out_data;

  periodic_timer_table #(.SLOTS(SLOTS)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

  ptt_pkg::req_t   request_fifo[$];
  ptt_pkg::rsp_t   expected_rsp[$];
  ptt_pkg::entry_t timer_tbl[SLOTS];
  int              timers_held = 0;
  int              mismatch_count = 0;
  int              result_index = 0;
  int              gap_left = 0;
  int              burst_left = 1;
  ptt_pkg::rsp_t   want;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #600000;
    $display("Mismatches found");
    $finish;
  end

  function automatic ptt_pkg::req_t req_of(logic [1:0] cmd, logic [15:0] key,
                                           logic [30:0] ival, logic [15:0] reps,
                                           logic [47:0] now);
    ptt_pkg::req_t r;
    r.command = cmd;
    r.timer_key = key;
    r.interval_ms = ival;
    r.repeat_count = reps;
    r.now_ms = now;
    return r;
  endfunction

  function automatic void drop_timer(int pos);
    for (int i = pos; i < timers_held - 1; i++) timer_tbl[i] = timer_tbl[i + 1];
    timers_held--;
  endfunction

  function automatic void predict_request(ptt_pkg::req_t r);
    int pos;
    int due_count;
    int k;
    ptt_pkg::rsp_t rsp;
    logic [48:0] due;
    bit is_due[SLOTS];
    bit run_out[SLOTS];
    pos = -1;
    k = 0;
    due_count = 0;
    for (int i = 0; i < timers_held; i++)
      if (pos < 0 && timer_tbl[i].key == r.timer_key) pos = i;
    rsp.status = ptt_pkg::STAT_OK;
    rsp.fired = 1'b0;
    rsp.fired_key = '0;
    rsp.last = 1'b1;
    case (r.command)
      ptt_pkg::CMD_ADD: begin
        if (pos >= 0) begin
          rsp.status = ptt_pkg::STAT_DUP;
        end else if (timers_held >= SLOTS) begin
          rsp.status = ptt_pkg::STAT_FULL;
        end else begin
          for (int i = timers_held; i > 0; i--) timer_tbl[i] = timer_tbl[i - 1];
          timer_tbl[0].valid = 1'b1;
          timer_tbl[0].key = r.timer_key;
          timer_tbl[0].interval = r.interval_ms;
          timer_tbl[0].remaining = r.repeat_count;
          timer_tbl[0].last_time = r.now_ms;
          timers_held++;
        end
      end
      ptt_pkg::CMD_DEL: begin
        if (timers_held == 0) rsp.status = ptt_pkg::STAT_EMPTY;
        else if (pos >= 0) drop_timer(pos);
      end
      ptt_pkg::CMD_CHK: begin
        for (int i = 0; i < SLOTS; i++) begin
          is_due[i] = 1'b0;
          run_out[i] = 1'b0;
        end
        for (int i = 0; i < timers_held; i++) begin
          due = {1'b0, timer_tbl[i].last_time} + 49'(timer_tbl[i].interval);
          if (due <= {1'b0, r.now_ms}) begin
            is_due[i] = 1'b1;
            due_count++;
          end
        end
        for (int i = 0; i < timers_held; i++) begin
          if (is_due[i]) begin
            rsp.fired = 1'b1;
            rsp.fired_key = timer_tbl[i].key;
            rsp.last = (k == due_count - 1);
            expected_rsp.push_back(rsp);
            k++;
            timer_tbl[i].last_time = timer_tbl[i].last_time + 48'(timer_tbl[i].interval);
            if (timer_tbl[i].remaining != 0) begin
              timer_tbl[i].remaining--;
              if (timer_tbl[i].remaining == 0) run_out[i] = 1'b1;
            end
          end
        end
        for (int i = SLOTS - 1; i >= 0; i--)
          if (run_out[i]) drop_timer(i);
        if (due_count == 0) begin
          rsp.fired = 1'b0;
          rsp.fired_key = '0;
          rsp.last = 1'b1;
          expected_rsp.push_back(rsp);
        end
      end
      default: ;
    endcase
    if (r.command != ptt_pkg::CMD_CHK) expected_rsp.push_back(rsp);
  endfunction

  // Request driver: holds start until the block takes the request.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_data <= '0;
    end else begin
      if (start && !busy) begin
        predict_request(in_data);
        void'(request_fifo.pop_front());
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 10);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (request_fifo.size() > 0) begin
          start <= 1'b1;
          in_data <= request_fifo[0];
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_strobe === 1'b1) begin
      if (expected_rsp.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: unexpected result %0d: status %0d fired %0b key %h last %0b",
                   result_index, out_data.status, out_data.fired, out_data.fired_key,
                   out_data.last);
      end else begin
        want = expected_rsp.pop_front();
        if (out_data.status !== want.status || out_data.fired !== want.fired ||
            out_data.fired_key !== want.fired_key || out_data.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: result %0d: expected %0d/%0b/%h/%0b, got %0d/%0b/%h/%0b",
                     result_index, want.status, want.fired, want.fired_key, want.last,
                     out_data.status, out_data.fired, out_data.fired_key, out_data.last);
        end
      end
      result_index++;
    end
  end

  initial begin
    logic [47:0] clock_ms;
    logic [1:0]  cmd;
    logic [15:0] key;
    logic [30:0] ival;
    logic [15:0] reps;
    logic [47:0] now;
    int          pick;

    request_fifo.push_back(req_of(ptt_pkg::CMD_CHK, 16'h0000, '0, '0, 48'd0));
    request_fifo.push_back(req_of(ptt_pkg::CMD_DEL, 16'h0000, '0, '0, 48'd0));
    request_fifo.push_back(req_of(CMD_NOP, 16'hFFFF, '1, '1, '1));
    request_fifo.push_back(req_of(ptt_pkg::CMD_ADD, 16'h0000, '0, '0, 48'd0));
    request_fifo.push_back(req_of(ptt_pkg::CMD_ADD, 16'h0000, 31'd5, 16'd2, 48'd7));
    request_fifo.push_back(req_of(ptt_pkg::CMD_ADD, 16'hFFFF, '1, '1, '1));
    request_fifo.push_back(req_of(ptt_pkg::CMD_CHK, 16'h0000, '0, '0, '1));
    for (int i = 1; i <= 14; i++)
      request_fifo.push_back(req_of(ptt_pkg::CMD_ADD, 16'(i), 31'(10 * i), 16'd1, 48'd100));
    request_fifo.push_back(req_of(ptt_pkg::CMD_ADD, 16'd100, 31'd1, 16'd0, 48'd100));
    request_fifo.push_back(req_of(ptt_pkg::CMD_CHK, 16'h0000, '0, '0, 48'd239));
    request_fifo.push_back(req_of(ptt_pkg::CMD_CHK, 16'h0000, '0, '0, 48'd240));
    request_fifo.push_back(req_of(ptt_pkg::CMD_DEL, 16'd500, '0, '0, 48'd240));
    request_fifo.push_back(req_of(ptt_pkg::CMD_DEL, 16'h0000, '0, '0, 48'd240));
    request_fifo.push_back(req_of(ptt_pkg::CMD_DEL, 16'hFFFF, '0, '0, 48'd240));

    clock_ms = 48'd1000;
    for (int n = 0; n < 143; n++) begin
      clock_ms = clock_ms + 48'($urandom_range(0, 40));
      pick = $urandom_range(0, 99);
      if (pick < 40) cmd = ptt_pkg::CMD_ADD;
      else if (pick < 60) cmd = ptt_pkg::CMD_DEL;
      else if (pick < 95) cmd = ptt_pkg::CMD_CHK;
      else cmd = CMD_NOP;
      key = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, 23)) : 16'($urandom);
      pick = $urandom_range(0, 9);
      if (pick < 8) ival = 31'($urandom_range(0, 60));
      else if (pick < 9) ival = 31'($urandom);
      else ival = $urandom_range(0, 1) ? '1 : '0;
      reps = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 3)) : 16'($urandom);
      now = ($urandom_range(0, 19) == 0) ? {16'($urandom), 32'($urandom)} : clock_ms;
      request_fifo.push_back(req_of(cmd, key, ival, reps, now));
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (request_fifo.size() != 0 || start || expected_rsp.size() != 0) @(posedge clk);
    repeat (2 * SLOTS + 8) @(posedge clk);
    if (mismatch_count == 0 && expected_rsp.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
